@@ rtl/core/accel_shock_peak_tracker_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the accel shock peak tracker.
// Shared check templates used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ACCEL_SHOCK_PEAK_TRACKER_DEFINES_SVH
`define ACCEL_SHOCK_PEAK_TRACKER_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define ASP_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/asp_pkg.sv @@
// ---------------------------------------------------------------------------
// asp_pkg
// Widths, constants and shared types of the accel shock peak tracker.
// ---------------------------------------------------------------------------
package asp_pkg;

  localparam int AXIS_W    = 16;
  localparam int RAW_SHIFT = 4;
  localparam int MAG_W     = AXIS_W - RAW_SHIFT;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int STEP_W    = $clog2(MAG_W);
  localparam int MG_W      = 16;
  localparam int CNT_W     = 32;
  localparam int THR_W     = 16;
  localparam int CODE_W    = 7;
  localparam int DIV_STEP_W = $clog2(CODE_W);

  localparam int MG_PER_LSB_INT = 186;
  localparam int SCALE_SHIFT    = 4;
  localparam int THR_RESET_INT  = 3500;
  localparam int CODE_MAX_INT   = 127;
  localparam int LSB_W          = 8;

  localparam logic [LSB_W-1:0]  MG_PER_LSB = LSB_W'(MG_PER_LSB_INT);
  localparam logic [THR_W-1:0]  THR_MIN    = THR_W'(MG_PER_LSB_INT);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(THR_RESET_INT);
  localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(CODE_MAX_INT);
  localparam logic [CODE_W-1:0] CODE_RESET =
    CODE_W'((THR_RESET_INT / MG_PER_LSB_INT > CODE_MAX_INT) ?
            CODE_MAX_INT : THR_RESET_INT / MG_PER_LSB_INT);
  localparam logic [THR_W-1:0]  CAP_LIMIT  = THR_W'(CODE_MAX_INT * MG_PER_LSB_INT);
  localparam logic [THR_W-1:0]  DIV_TOP    = THR_W'(MG_PER_LSB_INT << (CODE_W - 1));

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/core/asp_ifs.sv @@
// ---------------------------------------------------------------------------
// Channel interfaces
// Sample request, result and threshold write channels with valid/ready.
// ---------------------------------------------------------------------------
interface asp_in_if;
  import asp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, action, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, action, accel_x, accel_y, accel_z, output ready);
endinterface

interface asp_out_if;
  import asp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MG_W-1:0]   sample_mag;
  logic [MG_W-1:0]   peak_mg;
  logic              over_threshold;
  logic [CNT_W-1:0]  impact_count;
  logic [CODE_W-1:0] sensor_threshold_code;

  modport source (output valid, sample_mag, peak_mg, over_threshold, impact_count,
                  sensor_threshold_code, input ready);
  modport sink   (input valid, sample_mag, peak_mg, over_threshold, impact_count,
                  sensor_threshold_code, output ready);
endinterface

interface asp_cfg_if;
  import asp_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/asp_sumsq.sv @@
// ---------------------------------------------------------------------------
// asp_sumsq
// Bit-serial sum of squares of the three scaled axis magnitudes.
// ---------------------------------------------------------------------------
module asp_sumsq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [asp_pkg::AXIS_W-1:0] ax,
  input  logic signed [asp_pkg::AXIS_W-1:0] ay,
  input  logic signed [asp_pkg::AXIS_W-1:0] az,
  output logic        [asp_pkg::SQ_W-1:0]   sum,
  output asp_pkg::unit_stat_t               stat
);
  import asp_pkg::*;

  logic [MAG_W-1:0]  mx, my, mz;
  logic [SQ_W-1:0]   cx, cy, cz;
  logic [SQ_W-1:0]   acc;
  logic [SQ_W-1:0]   pp;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  // Truncation toward zero of a / 16 has magnitude floor(|a| / 16).
  function automatic logic [MAG_W-1:0] axis_mag(input logic signed [AXIS_W-1:0] a);
    logic [AXIS_W-1:0] u;
    u = a[AXIS_W-1] ? AXIS_W'(-a) : AXIS_W'(a);
    return u[AXIS_W-1:RAW_SHIFT];
  endfunction

  always_comb begin
    pp = (mx[0] ? cx : '0) + (my[0] ? cy : '0) + (mz[0] ? cz : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == STEP_W'(MAG_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx  <= axis_mag(ax);
      my  <= axis_mag(ay);
      mz  <= axis_mag(az);
      cx  <= SQ_W'(axis_mag(ax));
      cy  <= SQ_W'(axis_mag(ay));
      cz  <= SQ_W'(axis_mag(az));
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp;
      mx  <= mx >> 1;
      my  <= my >> 1;
      mz  <= mz >> 1;
      cx  <= cx << 1;
      cy  <= cy << 1;
      cz  <= cz << 1;
    end
  end

  assign sum       = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/core/asp_isqrt.sv @@
// ---------------------------------------------------------------------------
// asp_isqrt
// Restoring integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module asp_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [asp_pkg::SQ_W-1:0]       radicand,
  output logic [asp_pkg::ROOT_W-1:0]     root,
  output asp_pkg::unit_stat_t            stat
);
  import asp_pkg::*;

  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] res;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
    trial  = REM_W'({res, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == STEP_W'(ROOT_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      rem <= ge ? (rem_sh - trial) : rem_sh;
      res <= {res[ROOT_W-2:0], ge};
    end
  end

  assign root      = res;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/core/asp_thdiv.sv @@
// ---------------------------------------------------------------------------
// asp_thdiv
// Serial division of the threshold by the sensor step, capped code.
// ---------------------------------------------------------------------------
module asp_thdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [asp_pkg::THR_W-1:0]    th,
  output logic [asp_pkg::CODE_W-1:0]   code,
  output asp_pkg::unit_stat_t          stat
);
  import asp_pkg::*;

  logic [THR_W-1:0]      rem;
  logic [THR_W-1:0]      ds;
  logic [CODE_W-1:0]     q;
  logic                  cap;
  logic                  ge;
  logic [DIV_STEP_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  assign ge = rem >= ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      code <= CODE_RESET;
    end else begin
      done <= !start && busy && (cnt == DIV_STEP_W'(CODE_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_STEP_W'(CODE_W - 1)) begin
          busy <= 1'b0;
          code <= cap ? CODE_MAX : {q[CODE_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= th;
      ds  <= DIV_TOP;
      q   <= '0;
      cap <= th >= CAP_LIMIT;
    end else if (busy) begin
      rem <= ge ? (rem - ds) : rem;
      ds  <= ds >> 1;
      q   <= {q[CODE_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/core/accel_shock_peak_tracker.sv @@
// Flow: a sample request runs through the serial square sum (S_SQ), the serial
// square root (S_RT) and the scaling state (S_SC) to S_FIN, which loads the
// result once the output register is free; the next request is taken only after
// that. A take-peak request goes straight to S_FIN.
// A threshold write holds off requests while the code is divided.
// Reset clears the peak and the count and sets the threshold to 3500 mg.
// ---------------------------------------------------------------------------
// accel_shock_peak_tracker
// Vector magnitude peak hold and impact counter for accelerometer samples.
// ---------------------------------------------------------------------------
`include "accel_shock_peak_tracker_defines.svh"

module accel_shock_peak_tracker (
  input  logic       clk,
  input  logic       rst,
  asp_in_if.sink     sample,
  asp_out_if.source  result,
  asp_cfg_if.sink    cfg
);
  import asp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_RT   = 3'd2;
  localparam logic [2:0] S_SC   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]           state;
  logic                 take;
  logic [MG_W-1:0]      mag;
  logic [THR_W-1:0]     thr;
  logic [MG_W-1:0]      peak;
  logic [CNT_W-1:0]     impact_total;

  logic                 out_valid;
  logic [MG_W-1:0]      out_mag;
  logic [MG_W-1:0]      out_peak;
  logic                 out_over;
  logic [CNT_W-1:0]     out_cnt;
  logic [CODE_W-1:0]    out_code;

  logic                 in_fire;
  logic                 cfg_fire;
  logic [THR_W-1:0]     thr_wr;
  logic                 sq_start;
  logic                 rt_start;
  logic [SQ_W-1:0]      sq_sum;
  logic [ROOT_W-1:0]    root;
  logic [CODE_W-1:0]    code;
  unit_stat_t           sq_stat;
  unit_stat_t           rt_stat;
  unit_stat_t           div_stat;
  logic [ROOT_W+LSB_W-1:0] prod;
  logic                 load;
  logic                 over_c;
  logic [MG_W-1:0]      peak_up;

  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid & cfg.ready;
  assign thr_wr       = (cfg.data < THR_MIN) ? THR_MIN : cfg.data;

  assign sample.ready = (state == S_IDLE) && !div_stat.busy;
  assign in_fire      = sample.valid & sample.ready;
  assign sq_start     = in_fire && !sample.action;
  assign rt_start     = (state == S_SQ) && sq_stat.done;

  asp_sumsq u_sumsq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .ax    (sample.accel_x),
    .ay    (sample.accel_y),
    .az    (sample.accel_z),
    .sum   (sq_sum),
    .stat  (sq_stat)
  );

  asp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (sq_sum),
    .root     (root),
    .stat     (rt_stat)
  );

  asp_thdiv u_thdiv (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_fire),
    .th    (thr_wr),
    .code  (code),
    .stat  (div_stat)
  );

  always_comb begin
    prod    = (ROOT_W + LSB_W)'(root) * (ROOT_W + LSB_W)'(MG_PER_LSB);
    load    = (state == S_FIN) && (!out_valid || result.ready);
    over_c  = !take && (mag >= thr);
    peak_up = (mag > peak) ? mag : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      take         <= 1'b0;
      thr          <= THR_RESET;
      peak         <= '0;
      impact_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        thr <= thr_wr;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            take  <= sample.action;
            state <= sample.action ? S_FIN : S_SQ;
          end
        end
        S_SQ: begin
          if (sq_stat.done) begin
            state <= S_RT;
          end
        end
        S_RT: begin
          if (rt_stat.done) begin
            state <= S_SC;
          end
        end
        S_SC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
            if (take) begin
              peak <= '0;
            end else begin
              peak <= peak_up;
              if (over_c && (impact_total != '1)) begin
                impact_total <= impact_total + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && sample.action) begin
      mag <= '0;
    end else if (state == S_SC) begin
      mag <= prod[MG_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end
    if (load) begin
      out_mag  <= mag;
      out_peak <= take ? peak : peak_up;
      out_over <= over_c;
      out_cnt  <= (over_c && (impact_total != '1)) ? impact_total + 1'b1 : impact_total;
      out_code <= code;
    end
  end

  assign result.valid                 = out_valid;
  assign result.sample_mag            = out_mag;
  assign result.peak_mg               = out_peak;
  assign result.over_threshold        = out_over;
  assign result.impact_count          = out_cnt;
  assign result.sensor_threshold_code = out_code;

  `ASP_ASSERT_ALWAYS(a_units_exclusive, clk, rst, $onehot0({sq_stat.busy, rt_stat.busy}), "square and root units busy together")
  `ASP_ASSERT_IMPL(a_over_min, clk, rst, result.valid && result.over_threshold, result.sample_mag >= THR_MIN, "over threshold below minimum threshold")
  `ASP_ASSERT_IMPL(a_peak_covers, clk, rst, result.valid, result.peak_mg >= result.sample_mag, "peak below sample magnitude")
  `ASP_ASSERT_NEXT(a_count_monotonic, clk, rst, 1'b1, impact_total >= $past(impact_total), "impact count decreased")

endmodule

@@ tb/sv/accel_shock_peak_tracker_test.sv @@
// ---------------------------------------------------------------------------
// Accel shock peak tracker testbench
// Drives sample and take-peak requests and threshold writes with random
// idling, predicts every result in-line and compares each accepted result
// with the oldest prediction. A directed table opens the run, followed by
// random phases, each opened by its own threshold write.
// ---------------------------------------------------------------------------
module accel_shock_peak_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import asp_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TAKE   = 1'b1;
  localparam int N_DIRECTED   = 28;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 275;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic [MG_W-1:0]   mag;
    logic [MG_W-1:0]   peak;
    logic              over;
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] code;
  } shock_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [THR_W-1:0]  wdata;
    logic              action;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [AXIS_W-1:0] az;
    logic              typed;
    shock_report_t     fixed;
  } stim_row_t;

  localparam shock_report_t NO_REPORT = '0;

  // Rows with typed results hold values that follow directly from reset,
  // the axis extremes and the take-peak clearing.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'd0, 16'd0, 1'b0, 32'd0, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'd0, 16'd0, 1'b0, 32'd0, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 1'b1,
      '{16'd41233, 16'd41233, 1'b1, 32'd1, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'd0, 16'd41233, 1'b0, 32'd1, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'd0, 16'd0, 1'b0, 32'd1, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
      '{16'd41210, 16'd41210, 1'b1, 32'd2, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'hFFF1, 16'hFFF1, 16'hFFF1, 1'b1,
      '{16'd0, 16'd41210, 1'b0, 32'd2, 7'd18}},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'hFFEF, 16'h0010, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h8000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h7FFF, 16'hFFFF, 16'h5555, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'd4816, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h0000, 16'hED20, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h5555, 16'hAAAA, 16'h1234, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd0, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h0010, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0100, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd185, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h0000, 16'h0000, 16'hFF00, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'hFFFF, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd3499, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_SAMPLE, 16'd4816, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd23622, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd23621, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_SAMPLE, 16'd0, ACT_TAKE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{ROW_WRITE, 16'd3500, ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT}
  };

  logic clk;
  logic rst;

  asp_in_if  sample_ch ();
  asp_out_if result_ch ();
  asp_cfg_if cfg_ch ();

  accel_shock_peak_tracker uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [MG_W-1:0]  peak_q  = '0;
  logic [CNT_W-1:0] count_q = '0;
  logic [THR_W-1:0] thr_q   = THR_RESET;

  shock_report_t pending_reports [$];
  shock_report_t want_rep;
  shock_report_t got_rep;

  int requests_sent;
  int takes_sent;
  int writes_done;
  int overs_predicted;
  int reports_checked = 0;
  int mismatches      = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic shock_report_t track_sample(logic act, logic signed [AXIS_W-1:0] ax,
                                                 logic signed [AXIS_W-1:0] ay,
                                                 logic signed [AXIS_W-1:0] az);
    shock_report_t rep;
    int cx;
    int cy;
    int cz;
    int b;
    int unsigned sum;
    int unsigned root;
    int unsigned trial;
    int unsigned mag;
    int unsigned code;
    rep = '0;
    if (act == ACT_TAKE) begin
      rep.peak = peak_q;
      peak_q = '0;
    end else begin
      cx = int'(ax) / (1 << RAW_SHIFT);
      cy = int'(ay) / (1 << RAW_SHIFT);
      cz = int'(az) / (1 << RAW_SHIFT);
      sum = cx * cx + cy * cy + cz * cz;
      root = 0;
      for (b = ROOT_W - 1; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= sum) begin
          root = trial;
        end
      end
      mag = (root * MG_PER_LSB_INT) / (1 << SCALE_SHIFT);
      rep.mag = MG_W'(mag);
      if (rep.mag > peak_q) begin
        peak_q = rep.mag;
      end
      if (rep.mag >= thr_q) begin
        rep.over = 1'b1;
        if (count_q != '1) begin
          count_q = count_q + 1;
        end
      end
      rep.peak = peak_q;
    end
    rep.count = count_q;
    code = thr_q / MG_PER_LSB_INT;
    rep.code = (code > CODE_MAX_INT) ? CODE_MAX : CODE_W'(code);
    return rep;
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return AXIS_W'(int'($urandom_range(32)) - 16);
      3, 4: return AXIS_W'(int'($urandom_range(8000)) - 4000);
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  task automatic request_sample(logic act, logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay,
                                logic [AXIS_W-1:0] az, logic typed, shock_report_t fixed);
    shock_report_t rep;
    bit quiet;
    cfg_ch.valid <= 1'b0;
    quiet = (requests_sent >= 800) && (requests_sent < 1100);
    while (!quiet && $urandom_range(99) < 16) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.action  <= act;
    sample_ch.accel_x <= ax;
    sample_ch.accel_y <= ay;
    sample_ch.accel_z <= az;
    do @(posedge clk); while (!sample_ch.ready);
    rep = track_sample(act, ax, ay, az);
    pending_reports.push_back(typed ? fixed : rep);
    requests_sent++;
    if (act == ACT_TAKE) begin
      takes_sent++;
    end
    if (rep.over) begin
      overs_predicted++;
    end
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    sample_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    thr_q = (value < THR_MIN) ? THR_MIN : value;
    writes_done++;
  endtask

  // The receiver idles at random, except for one quiet window, and once holds
  // off long enough that the block fills up and stalls its request side.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!hold_done && reports_checked >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (reports_checked >= 800 && reports_checked < 1100) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_rep = '{result_ch.sample_mag, result_ch.peak_mg, result_ch.over_threshold,
                  result_ch.impact_count, result_ch.sensor_threshold_code};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with no request pending: mag %0d peak %0d over %0b cnt %0d code %0d",
                   $realtime, got_rep.mag, got_rep.peak, got_rep.over, got_rep.count,
                   got_rep.code);
        end
      end else begin
        want_rep = pending_reports.pop_front();
        if (got_rep !== want_rep) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, reports_checked);
            $display("  expected mag %0d peak %0d over %0b cnt %0d code %0d",
                     want_rep.mag, want_rep.peak, want_rep.over, want_rep.count,
                     want_rep.code);
            $display("  actual   mag %0d peak %0d over %0b cnt %0d code %0d",
                     got_rep.mag, got_rep.peak, got_rep.over, got_rep.count,
                     got_rep.code);
          end
        end
      end
      reports_checked++;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase;
    int i;
    logic [THR_W-1:0] thr;
    rst = 1'b1;
    sample_ch.valid   = 1'b0;
    sample_ch.action  = ACT_SAMPLE;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    requests_sent     = 0;
    takes_sent        = 0;
    writes_done       = 0;
    overs_predicted   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_threshold(directed_rows[i].wdata);
      end else begin
        request_sample(directed_rows[i].action, directed_rows[i].ax, directed_rows[i].ay,
                       directed_rows[i].az, directed_rows[i].typed, directed_rows[i].fixed);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: thr = THR_W'($urandom_range(4000, 186));
        1: thr = 16'hFFFF;
        2: thr = 16'd0;
        3: thr = THR_W'($urandom_range(41233, 20000));
        4: thr = THR_W'($urandom_range(185));
        default: thr = THR_W'($urandom);
      endcase
      write_threshold(thr);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        request_sample(($urandom_range(99) < 12) ? ACT_TAKE : ACT_SAMPLE,
                       pick_axis(), pick_axis(), pick_axis(), 1'b0, NO_REPORT);
      end
    end

    sample_ch.valid <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d requests (%0d take-peak, %0d over threshold).",
             reports_checked, requests_sent, takes_sent, overs_predicted);
    $display("Applied %0d threshold writes including clamped and saturated codes; %0d mismatches.",
             writes_done, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ accel_shock_peak_tracker.f @@
+incdir+rtl/core
rtl/core/asp_pkg.sv
rtl/core/asp_ifs.sv
rtl/core/asp_sumsq.sv
rtl/core/asp_isqrt.sv
rtl/core/asp_thdiv.sv
rtl/core/accel_shock_peak_tracker.sv
tb/sv/accel_shock_peak_tracker_test.sv
